// File: sv/bhs_pkg.sv
// Shared types and constants for the bucketed hash set core.
// Request/response payloads, operation codes and controller/datapath command and status.
// No dependencies.
package bhs_pkg;

  localparam int KEY_W = 32;

  // Remainder unit: reciprocal multiply, multiply-subtract, final correction
  localparam int MOD_STEPS = 3;
  localparam int MOD_CW    = $clog2(MOD_STEPS);

  // Operation codes; any other code acts as a search
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic found;
    logic bucket_full;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_we;    // write one zero row of the clearing pass
    logic load;      // capture a request and restart the remainder
    logic mod_step;  // advance the remainder unit by one stage
    logic rd;        // read the bucket row
    logic commit;    // write back the row and load the response
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
  } dp_sts_t;

endpackage

// File: sv/bhs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read.
// No dependencies.
module bhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bhs_ctrl.sv
// Controller state machine for the bucketed hash set core.
// Sequences clearing, remainder, read and write-back; owns the handshakes.
// Depends on bhs_pkg.
module bhs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bhs_pkg::dp_cmd_t  cmd,
  input  bhs_pkg::dp_sts_t  sts
);
  import bhs_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_LOOK  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        // Hold until the response register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Response valid: set on commit, drop after transfer
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: sv/bhs_dp.sv
// Datapath for the bucketed hash set core: bucket remainder unit, bucket row RAM,
// way compare and row update, response register.
// Depends on bhs_pkg and bhs_ram.
module bhs_dp #(
  parameter int BUCKETS = 128,
  parameter int WAYS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  bhs_pkg::dp_cmd_t  cmd,
  output bhs_pkg::dp_sts_t  sts,
  input  bhs_pkg::req_t     req,
  output bhs_pkg::rsp_t     rsp
);
  import bhs_pkg::*;

  localparam int BW    = $clog2(BUCKETS);
  localparam int RW    = BW + 2;
  localparam int ROW_W = WAYS * (KEY_W + 1);
  localparam int KEYS_W = WAYS * KEY_W;

  // Reciprocal of the bucket count, scaled by 2^KEY_W
  localparam logic [KEY_W-1:0] RECIP = KEY_W'(64'h1_0000_0000 / 64'(BUCKETS));
  // Remainder of the sign-extension word, added for negative keys
  localparam logic [BW-1:0] SIGN_REM = BW'(64'hFFFF_FFFF_0000_0000 % 64'(BUCKETS));
  localparam logic [RW-1:0] BKT      = RW'(BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);
  localparam logic [MOD_CW-1:0] LAST_STEP = MOD_CW'(MOD_STEPS - 1);

  logic [1:0]        req_kind;
  logic [KEY_W-1:0]  req_key;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  quot_next;
  logic [KEY_W-1:0]  back;
  logic [RW-1:0]     diff;
  logic [RW-1:0]     rem_est;
  logic [RW-1:0]     red1;
  logic [RW-1:0]     red2;
  logic [BW-1:0]     rem;
  logic [BW-1:0]     rem_next;
  logic [MOD_CW-1:0] mod_cnt;
  logic [BW-1:0]     clr_addr;

  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;
  logic [WAYS-1:0]   row_valid;
  logic [KEYS_W-1:0] row_keys;
  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   hit_oh;
  logic [WAYS-1:0]   free_oh;
  logic [WAYS-1:0]   new_valid;
  logic [KEYS_W-1:0] new_keys;
  logic              found;
  logic              have_free;
  logic              is_ins;
  logic              is_rem;
  logic              do_ins;
  logic              do_rem;
  logic              ram_we;

  // Remainder by reciprocal multiply: the quotient estimate is low by at most one,
  // so one correction gives the unsigned key remainder; then add the sign term
  always_comb begin
    quot_next = KEY_W'(((2*KEY_W)'(req_key) * (2*KEY_W)'(RECIP)) >> KEY_W);
    back      = quot * KEY_W'(BUCKETS);
    diff      = RW'(req_key - back);
    red1      = (rem_est >= BKT) ? rem_est - BKT : rem_est;
    red2      = red1 + (req_key[KEY_W-1] ? RW'(SIGN_REM) : RW'(0));
    rem_next  = (red2 >= BKT) ? BW'(red2 - BKT) : red2[BW-1:0];
  end

  // Capture request, then advance the three remainder stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= req.kind;
      req_key  <= req.key;
      mod_cnt  <= '0;
    end else if (cmd.mod_step) begin
      quot    <= quot_next;
      rem_est <= diff;
      rem     <= rem_next;
      mod_cnt <= mod_cnt + 1'b1;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr == LAST_ROW);
  assign sts.mod_last = (mod_cnt == LAST_STEP);

  // Compare ways against the key
  assign row_valid = rd_row[ROW_W-1 -: WAYS];
  assign row_keys  = rd_row[KEYS_W-1:0];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_valid[w] && (row_keys[w*KEY_W +: KEY_W] == req_key);
    end
  end

  // Lowest matching way and lowest free way
  assign hit_oh    = match & (~match + WAYS'(1));
  assign free_oh   = ~row_valid & (row_valid + WAYS'(1));
  assign found     = |match;
  assign have_free = |free_oh;

  assign is_ins = (req_kind == KIND_INSERT);
  assign is_rem = (req_kind == KIND_REMOVE);
  assign do_ins = is_ins && !found && have_free;
  assign do_rem = is_rem && found;

  // Build the updated row
  always_comb begin
    new_valid = row_valid;
    if (do_ins) begin
      new_valid = row_valid | free_oh;
    end else if (do_rem) begin
      new_valid = row_valid & ~hit_oh;
    end
    for (int w = 0; w < WAYS; w++) begin
      new_keys[w*KEY_W +: KEY_W] = (do_ins && free_oh[w]) ? req_key
                                                         : row_keys[w*KEY_W +: KEY_W];
    end
  end

  assign ram_we = cmd.clr_we || (cmd.commit && (do_ins || do_rem));
  assign wr_row = cmd.clr_we ? '0 : {new_valid, new_keys};

  bhs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cmd.clr_we ? clr_addr : rem),
    .wr_data (wr_row),
    .rd_en   (cmd.rd),
    .rd_addr (rem),
    .rd_data (rd_row)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.found       <= found;
      rsp.bucket_full <= is_ins && !found && !have_free;
    end
  end

endmodule

// File: sv/bucketed_hash_set_core.sv
// Top level of the bucketed hash set core: controller plus datapath.
// Depends on bhs_pkg, bhs_ctrl, bhs_dp (which holds bhs_ram).
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_t {kind, key}
//   rsp      out  rsp_valid/rsp_ready   rsp_t {found, bucket_full}
//
// Each request passes from transfer to response through the remainder unit
// (reciprocal multiply, multiply-subtract, correction), a bucket row read, and a
// compare and write-back. One request is in flight at a time, so the next request
// is not taken before the last one is through; the next transfer is taken while a
// response waits. After reset a clearing pass writes BUCKETS rows, one per cycle,
// before req_ready rises. A stalled response holds write-back of the following
// request until it transfers.
module bucketed_hash_set_core #(
  parameter int BUCKETS = 128,
  parameter int WAYS    = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bhs_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bhs_pkg::rsp_t  rsp
);
  import bhs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bhs_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule
